[src/cbri_pkg.sv]
// Shared types and constants for the counting binary search tree block.
// Used by the controller, the datapath, the top level and the checker.
// Depends on nothing.
package cbri_pkg;

   localparam int NodeSlotsDefault = 1024;
   localparam logic [30:0] TotalLimit = 31'h7fffffff;

   typedef enum logic [1:0] {
      STATUS_OK          = 2'd0,
      STATUS_BAD_COUNT   = 2'd1,
      STATUS_TOTAL_LIMIT = 2'd2,
      STATUS_STORE_FULL  = 2'd3
   } status_type;

   typedef struct packed {
      logic signed [63:0] value;
      logic [31:0]        count;
      logic               restart;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [30:0] less_total;
      logic [30:0] equal_total;
      logic [30:0] greater_total;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_PROBE,
      ST_WALK,
      ST_FILL,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic       accept;
      logic       clear;
      logic       read_root;
      logic       probe;
      logic       walk;
      logic       fill;
      logic       finish;
      status_type code;
   } cmd_type;

   typedef struct packed {
      logic bad_count;
      logic empty;
      logic over_total;
      logic full;
      logic hit;
      logic leaf;
      logic out_free;
   } flags_type;

endpackage

[src/counting_bst_rank_insert.sv]
// Top level of the counting binary search tree with rank results.
// Joins cbri_ctrl and cbri_dp; uses cbri_pkg.
//
// Each request on the req_ channel adds count copies of a signed 64-bit value
// to a multiset held in a tree of NODE_SLOTS node slots, and produces one
// response on the rsp_ channel with a status and the numbers of stored
// elements below, equal to and above the value after the insert.
// One request is worked on at a time; req_stall is low only when idle.
// A request walks the tree once along its search path, reading one node per
// cycle from the node memory, and creates a new node when the value is not
// found. When every slot is in use, a search pass without updates runs first,
// so the path is walked twice when the value is found; the depth of the
// unbalanced tree sets how long a request takes. Rejected counts skip it.
// The response sits in an output register, so the next request can be
// accepted while rsp_stall holds the previous response.
// Reset empties the store at once; the node memory needs no clearing.
module counting_bst_rank_insert #(
   parameter int NODE_SLOTS = cbri_pkg::NodeSlotsDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  cbri_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output cbri_pkg::rsp_type rsp_data
);

   cbri_pkg::cmd_type   cmd;
   cbri_pkg::flags_type flags;

   cbri_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .flags     (flags),
      .cmd       (cmd)
   );

   cbri_dp #(
      .NODE_SLOTS (NODE_SLOTS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .flags     (flags),
      .rsp_data  (rsp_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall)
   );

endmodule

[src/cbri_dp.sv]
// Datapath of the counting binary search tree: node memory, walk registers,
// running totals and the result register. Uses cbri_pkg; driven by cbri_ctrl.
module cbri_dp #(
   parameter int NODE_SLOTS = cbri_pkg::NodeSlotsDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  cbri_pkg::req_type req_data,
   input  cbri_pkg::cmd_type cmd,
   output cbri_pkg::flags_type flags,
   output cbri_pkg::rsp_type rsp_data,
   output logic              rsp_valid,
   input  logic              rsp_stall
);

   localparam int IW = $clog2(NODE_SLOTS);
   localparam int CW = $clog2(NODE_SLOTS + 1);

   typedef struct packed {
      logic signed [63:0] value;
      logic [IW-1:0]      left_child;
      logic [IW-1:0]      right_child;
      logic [30:0]        left_total;
      logic [30:0]        own_total;
      logic [30:0]        right_total;
   } node_type;

   node_type mem [NODE_SLOTS];

   cbri_pkg::req_type req_ff;
   node_type          rd_ff;
   logic [IW-1:0]     node_ff;
   logic [CW-1:0]     slots_ff, slots_in;
   logic [30:0]       total_ff, total_in;
   logic [30:0]       lt_ff, lt_in, eq_ff, eq_in, gt_ff, gt_in;
   cbri_pkg::rsp_type rsp_ff;
   logic              rsp_valid_ff, rsp_valid_in;

   logic [30:0]   count31;
   logic          is_less;
   logic [IW-1:0] next_child;
   logic          wr_en;
   logic [IW-1:0] wr_addr;
   node_type      wr_data;
   logic          rd_en;
   logic [IW-1:0] rd_addr;
   logic [32:0]   sum_total;

   assign count31    = req_ff.count[30:0];
   assign is_less    = $signed(rd_ff.value) < $signed(req_ff.value);
   assign next_child = is_less ? rd_ff.right_child : rd_ff.left_child;
   assign sum_total  = {2'b00, total_ff} + {1'b0, req_ff.count};

   assign flags.bad_count  = (req_ff.count == 32'd0) || req_ff.count[31];
   assign flags.empty      = req_ff.restart || (slots_ff == '0);
   assign flags.over_total = sum_total > {2'b00, cbri_pkg::TotalLimit};
   assign flags.full       = slots_ff == CW'(NODE_SLOTS);
   assign flags.hit        = rd_ff.value == req_ff.value;
   assign flags.leaf       = next_child == '0;
   assign flags.out_free   = !rsp_valid_ff || !rsp_stall;

   assign rd_en   = cmd.read_root || cmd.probe || cmd.walk;
   assign rd_addr = cmd.read_root ? '0 : next_child;

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = node_ff;
      wr_data = rd_ff;
      if (cmd.walk) begin
         wr_en = 1'b1;
         if (flags.hit) begin
            wr_data.own_total = rd_ff.own_total + count31;
         end else if (is_less) begin
            wr_data.right_total = rd_ff.right_total + count31;
            if (flags.leaf) begin
               wr_data.right_child = slots_ff[IW-1:0];
            end
         end else begin
            wr_data.left_total = rd_ff.left_total + count31;
            if (flags.leaf) begin
               wr_data.left_child = slots_ff[IW-1:0];
            end
         end
      end else if (cmd.fill) begin
         wr_en               = 1'b1;
         wr_addr             = slots_ff[IW-1:0];
         wr_data.value       = req_ff.value;
         wr_data.left_child  = '0;
         wr_data.right_child = '0;
         wr_data.left_total  = '0;
         wr_data.own_total   = count31;
         wr_data.right_total = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_ff   <= mem[rd_addr];
         node_ff <= rd_addr;
      end
      if (cmd.accept) begin
         req_ff <= req_data;
      end
   end

   always_comb begin
      lt_in        = lt_ff;
      eq_in        = eq_ff;
      gt_in        = gt_ff;
      total_in     = total_ff;
      slots_in     = slots_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.accept) begin
         lt_in = '0;
         eq_in = '0;
         gt_in = '0;
      end
      if (cmd.clear) begin
         slots_in = '0;
         total_in = '0;
      end
      if (cmd.walk) begin
         if (flags.hit) begin
            lt_in    = lt_ff + rd_ff.left_total;
            gt_in    = gt_ff + rd_ff.right_total;
            eq_in    = rd_ff.own_total + count31;
            total_in = total_ff + count31;
         end else if (is_less) begin
            lt_in = lt_ff + rd_ff.own_total + rd_ff.left_total;
         end else begin
            gt_in = gt_ff + rd_ff.own_total + rd_ff.right_total;
         end
      end
      if (cmd.fill) begin
         eq_in    = count31;
         total_in = total_ff + count31;
         slots_in = slots_ff + CW'(1);
      end
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slots_ff     <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         slots_ff     <= slots_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lt_ff <= lt_in;
      eq_ff <= eq_in;
      gt_ff <= gt_in;
      if (cmd.finish) begin
         rsp_ff.status <= cmd.code;
         if (cmd.code == cbri_pkg::STATUS_OK) begin
            rsp_ff.less_total    <= lt_ff;
            rsp_ff.equal_total   <= eq_ff;
            rsp_ff.greater_total <= gt_ff;
         end else begin
            rsp_ff.less_total    <= '0;
            rsp_ff.equal_total   <= '0;
            rsp_ff.greater_total <= '0;
         end
      end
   end

   assign rsp_data  = rsp_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

[src/cbri_ctrl.sv]
// Controller state machine of the counting binary search tree.
// Uses cbri_pkg; issues commands to cbri_dp and reads its flags.
module cbri_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  cbri_pkg::flags_type flags,
   output cbri_pkg::cmd_type   cmd
);

   cbri_pkg::state_type  state_ff, state_in;
   cbri_pkg::status_type code_ff, code_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cbri_pkg::ST_IDLE;
         code_ff  <= cbri_pkg::STATUS_OK;
      end else begin
         state_ff <= state_in;
         code_ff  <= code_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      code_in   = code_ff;
      cmd       = '0;
      cmd.code  = code_ff;
      req_stall = 1'b1;
      case (state_ff)
         cbri_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = cbri_pkg::ST_CHECK;
            end
         end
         cbri_pkg::ST_CHECK: begin
            if (flags.bad_count) begin
               code_in  = cbri_pkg::STATUS_BAD_COUNT;
               state_in = cbri_pkg::ST_DONE;
            end else if (flags.empty) begin
               cmd.clear = 1'b1;
               code_in   = cbri_pkg::STATUS_OK;
               state_in  = cbri_pkg::ST_FILL;
            end else if (flags.over_total) begin
               code_in  = cbri_pkg::STATUS_TOTAL_LIMIT;
               state_in = cbri_pkg::ST_DONE;
            end else begin
               cmd.read_root = 1'b1;
               code_in       = cbri_pkg::STATUS_OK;
               state_in      = flags.full ? cbri_pkg::ST_PROBE : cbri_pkg::ST_WALK;
            end
         end
         cbri_pkg::ST_PROBE: begin
            if (flags.hit) begin
               cmd.read_root = 1'b1;
               state_in      = cbri_pkg::ST_WALK;
            end else if (flags.leaf) begin
               code_in  = cbri_pkg::STATUS_STORE_FULL;
               state_in = cbri_pkg::ST_DONE;
            end else begin
               cmd.probe = 1'b1;
            end
         end
         cbri_pkg::ST_WALK: begin
            cmd.walk = 1'b1;
            if (flags.hit) begin
               state_in = cbri_pkg::ST_DONE;
            end else if (flags.leaf) begin
               state_in = cbri_pkg::ST_FILL;
            end
         end
         cbri_pkg::ST_FILL: begin
            cmd.fill = 1'b1;
            state_in = cbri_pkg::ST_DONE;
         end
         cbri_pkg::ST_DONE: begin
            if (flags.out_free) begin
               cmd.finish = 1'b1;
               state_in   = cbri_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = cbri_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

[src/cbri_checker.sv]
// Port-level checks for the counting binary search tree top level.
// Uses cbri_pkg; bound to counting_bst_rank_insert.
module cbri_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input cbri_pkg::rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("Stalled response changed.");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("Request accepted while another was in progress.");

   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != cbri_pkg::STATUS_OK |->
         rsp_data.less_total == '0 && rsp_data.equal_total == '0 &&
         rsp_data.greater_total == '0)
      else $error("Rejected request returned nonzero counts.");

   a_ok_has_equal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == cbri_pkg::STATUS_OK |->
         rsp_data.equal_total != '0)
      else $error("Accepted insert returned no equal elements.");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("Response valid right after reset.");

endmodule

bind counting_bst_rank_insert cbri_checker u_cbri_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
